/* rtl/lcm_of_three_assert.svh */
// Assertion macros for the lcm_of_three block.
// Included by the top level; depends on nothing else.
`ifndef LCM_OF_THREE_ASSERT_SVH
`define LCM_OF_THREE_ASSERT_SVH

// The expression must hold at every clock edge outside reset.
`define LCM_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("lcm_of_three: invariant violated");

// When the antecedent holds, the consequent must hold at the same edge.
`define LCM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lcm_of_three: implication violated");

`endif

/* rtl/lcm3_pkg.sv */
// Shared constants for the lcm_of_three block.
// Used by the top level and its serial arithmetic units; depends on nothing.
package lcm3_pkg;

    localparam int OPERAND_WIDTH = 16;

endpackage

/* rtl/lcm3_div.sv */
// Restoring divider that retires one quotient bit per cycle.
// Divides a 2*W-bit dividend by a W-bit divisor; depends on lcm3_pkg.
module lcm3_div #(
    parameter int W = lcm3_pkg::OPERAND_WIDTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [2*W-1:0] dividend,
    input  logic [W-1:0]   divisor,
    output logic           done,
    output logic [2*W-1:0] quotient,
    output logic [W-1:0]   remainder
);

    localparam int CW = $clog2(2 * W);
    localparam logic [CW-1:0] LAST = CW'(2 * W - 1);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [2*W-1:0] quo_reg, quo_next;
    logic [W-1:0]   rem_reg, rem_next;

    logic [W:0] trial;
    logic [W:0] diff;
    logic       ge;

    assign trial = {rem_reg, quo_reg[2*W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign ge    = (trial >= {1'b0, divisor});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (busy_reg) begin
            rem_next = ge ? diff[W-1:0] : trial[W-1:0];
            quo_next = {quo_reg[2*W-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            busy_next = 1'b1;
            cnt_next  = LAST;
            quo_next  = dividend;
            rem_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/lcm3_gcd.sv */
// Binary GCD unit that performs one shift or subtract per cycle.
// The second operand must be nonzero; depends on lcm3_pkg.
module lcm3_gcd #(
    parameter int W = lcm3_pkg::OPERAND_WIDTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] x_in,
    input  logic [W-1:0] y_in,
    output logic         done,
    output logic [W-1:0] gcd_out
);

    localparam int KW = $clog2(W);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [KW-1:0] k_reg, k_next;
    logic [W-1:0]  x_reg, x_next;
    logic [W-1:0]  y_reg, y_next;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        k_next    = k_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        if (busy_reg) begin
            if (x_reg == '0) begin
                if (k_reg == '0) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end else begin
                    y_next = {y_reg[W-2:0], 1'b0};
                    k_next = k_reg - KW'(1);
                end
            end else if (!x_reg[0] && !y_reg[0]) begin
                x_next = x_reg >> 1;
                y_next = y_reg >> 1;
                k_next = k_reg + KW'(1);
            end else if (!x_reg[0]) begin
                x_next = x_reg >> 1;
            end else if (!y_reg[0]) begin
                y_next = y_reg >> 1;
            end else if (x_reg >= y_reg) begin
                x_next = x_reg - y_reg;
            end else begin
                x_next = y_reg - x_reg;
                y_next = x_reg;
            end
        end else if (start) begin
            busy_next = 1'b1;
            k_next    = '0;
            x_next    = x_in;
            y_next    = y_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            k_reg    <= k_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
    end

    assign done    = done_reg;
    assign gcd_out = y_reg;

endmodule

/* rtl/lcm_of_three.sv */
// Least common multiple of three unsigned operands, one item at a time.
// The steps are a GCD, a divide, a multiply, a divide, a second GCD, a divide and a second multiply,
// with data-dependent GCD loops: three divider passes and two serial shift-add multiplies in all.
// A zero operand skips the arithmetic and gives a zero result; the next transaction can be accepted
// as soon as the result is registered. Synchronous active-low reset clears the sequencer
// and the output valid flag.
module lcm_of_three #(
    parameter int OPERAND_WIDTH = lcm3_pkg::OPERAND_WIDTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [OPERAND_WIDTH-1:0]   s_first_operand,
    input  logic [OPERAND_WIDTH-1:0]   s_second_operand,
    input  logic [OPERAND_WIDTH-1:0]   s_third_operand,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [3*OPERAND_WIDTH-1:0] m_multiple
);

    `include "lcm_of_three_assert.svh"

    localparam int W  = OPERAND_WIDTH;
    localparam int MW = $clog2(W + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GCD1,
        ST_DIV1,
        ST_MUL1,
        ST_DIV2,
        ST_GCD2,
        ST_DIV3,
        ST_MUL2,
        ST_FIN
    } state_t;

    state_t         state_reg, state_next;
    logic           gcd_start_reg, gcd_start_next;
    logic           div_start_reg, div_start_next;
    logic           m_valid_reg, m_valid_next;
    logic [3*W-1:0] m_multiple_reg, m_multiple_next;
    logic [W-1:0]   a_reg, a_next;
    logic [W-1:0]   b_reg, b_next;
    logic [W-1:0]   c_reg, c_next;
    logic [2*W-1:0] l_reg, l_next;
    logic [2*W-1:0] mcand_reg, mcand_next;
    logic [W-1:0]   mult_reg, mult_next;
    logic [3*W-1:0] acc_reg, acc_next;
    logic [MW-1:0]  mcnt_reg, mcnt_next;

    logic [W-1:0]   gcd_x, gcd_y, gcd_out;
    logic           gcd_done;
    logic [2*W-1:0] div_dividend, div_quo;
    logic [W-1:0]   div_divisor, div_rem;
    logic           div_done;
    logic [3*W-1:0] acc_step;

    always_comb begin
        gcd_x = a_reg;
        gcd_y = b_reg;
        if (state_reg == ST_GCD2) begin
            gcd_x = div_rem;
            gcd_y = c_reg;
        end
    end

    always_comb begin
        case (state_reg)
            ST_DIV2: begin
                div_dividend = l_reg;
                div_divisor  = c_reg;
            end
            ST_DIV3: begin
                div_dividend = {{W{1'b0}}, c_reg};
                div_divisor  = gcd_out;
            end
            default: begin
                div_dividend = {{W{1'b0}}, a_reg};
                div_divisor  = gcd_out;
            end
        endcase
    end

    lcm3_gcd #(.W(W)) u_gcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (gcd_start_reg),
        .x_in    (gcd_x),
        .y_in    (gcd_y),
        .done    (gcd_done),
        .gcd_out (gcd_out)
    );

    lcm3_div #(.W(W)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start_reg),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign acc_step = {acc_reg[3*W-2:0], 1'b0}
                    + (mult_reg[W-1] ? {{W{1'b0}}, mcand_reg} : {(3*W){1'b0}});

    always_comb begin
        state_next      = state_reg;
        gcd_start_next  = 1'b0;
        div_start_next  = 1'b0;
        m_valid_next    = m_valid_reg;
        m_multiple_next = m_multiple_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        c_next          = c_reg;
        l_next          = l_reg;
        mcand_next      = mcand_reg;
        mult_next       = mult_reg;
        acc_next        = acc_reg;
        mcnt_next       = mcnt_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    a_next = s_first_operand;
                    b_next = s_second_operand;
                    c_next = s_third_operand;
                    if (s_first_operand == '0 || s_second_operand == '0 ||
                        s_third_operand == '0) begin
                        acc_next   = '0;
                        state_next = ST_FIN;
                    end else begin
                        gcd_start_next = 1'b1;
                        state_next     = ST_GCD1;
                    end
                end
            end
            ST_GCD1: begin
                if (gcd_done) begin
                    div_start_next = 1'b1;
                    state_next     = ST_DIV1;
                end
            end
            ST_DIV1: begin
                if (div_done) begin
                    mult_next  = div_quo[W-1:0];
                    mcand_next = {{W{1'b0}}, b_reg};
                    acc_next   = '0;
                    mcnt_next  = MW'(W);
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: begin
                acc_next  = acc_step;
                mult_next = {mult_reg[W-2:0], 1'b0};
                mcnt_next = mcnt_reg - MW'(1);
                if (mcnt_reg == MW'(1)) begin
                    l_next         = acc_step[2*W-1:0];
                    div_start_next = 1'b1;
                    state_next     = ST_DIV2;
                end
            end
            ST_DIV2: begin
                if (div_done) begin
                    gcd_start_next = 1'b1;
                    state_next     = ST_GCD2;
                end
            end
            ST_GCD2: begin
                if (gcd_done) begin
                    div_start_next = 1'b1;
                    state_next     = ST_DIV3;
                end
            end
            ST_DIV3: begin
                if (div_done) begin
                    mult_next  = div_quo[W-1:0];
                    mcand_next = l_reg;
                    acc_next   = '0;
                    mcnt_next  = MW'(W);
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2: begin
                acc_next  = acc_step;
                mult_next = {mult_reg[W-2:0], 1'b0};
                mcnt_next = mcnt_reg - MW'(1);
                if (mcnt_reg == MW'(1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_multiple_next = acc_reg;
                    m_valid_next    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            gcd_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            mcnt_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            gcd_start_reg <= gcd_start_next;
            div_start_reg <= div_start_next;
            m_valid_reg   <= m_valid_next;
            mcnt_reg      <= mcnt_next;
        end
        m_multiple_reg <= m_multiple_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        c_reg          <= c_next;
        l_reg          <= l_next;
        mcand_reg      <= mcand_next;
        mult_reg       <= mult_next;
        acc_reg        <= acc_next;
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_multiple = m_multiple_reg;

    `LCM_ASSERT_IMPLY(a_div_done_in_div, aclk, aresetn, div_done, (state_reg == ST_DIV1 || state_reg == ST_DIV2 || state_reg == ST_DIV3))
    `LCM_ASSERT_IMPLY(a_gcd_done_in_gcd, aclk, aresetn, gcd_done, (state_reg == ST_GCD1 || state_reg == ST_GCD2))
    `LCM_ASSERT_IMPLY(a_gcd_divides_third, aclk, aresetn, (state_reg == ST_DIV3 && div_done), (div_rem == '0))
    `LCM_ASSERT_ALWAYS(a_mul1_fits, aclk, aresetn, (state_reg != ST_MUL1 || acc_reg[3*W-1:2*W] == '0))

endmodule
